>>> design/sds_pkg.sv
// Shared types and constants for the synthesizer divider select block.
// Used by sds_cell and synthesizer_divider_select; no other dependencies.
package sds_pkg;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REF_RANGE = 3'd1;
  localparam logic [2:0] ST_ABOVE_VCO = 3'd2;
  localparam logic [2:0] ST_BELOW_VCO = 3'd3;
  localparam logic [2:0] ST_MAIN_RNG  = 3'd4;

  // Frequency limits in kHz.
  localparam logic [19:0] VCO_MAX_KHZ    = 20'd800000;
  localparam logic [19:0] TARGET_MIN_KHZ = 20'd50000;
  localparam logic [19:0] NP2_MAX_KHZ    = 20'd400000;
  localparam logic [19:0] NP3_MAX_KHZ    = 20'd200000;
  localparam logic [19:0] NP4_MAX_KHZ    = 20'd100000;
  localparam logic [14:0] REF_MIN_KHZ    = 15'd10000;
  localparam logic [14:0] REF_MAX_KHZ    = 15'd20000;
  localparam logic [14:0] REF_RESET_KHZ  = 15'd16000;
  localparam logic [9:0]  MAIN_MAX       = 10'h1ff;

  // Number of quotient bits, one cell each.
  localparam int QUO_BITS = 10;

  // One beat as it travels down the divider chain.
  typedef struct packed {
    logic        vld;
    logic [2:0]  status;
    logic [2:0]  np;
    logic [14:0] fref;
    logic [11:0] dvs;
    logic [11:0] rem;
    logic [9:0]  dvd;
    logic [9:0]  quo;
  } sds_beat_t;

endpackage

>>> design/sds_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
// Depends on sds_pkg for the beat type.
module sds_cell (
  input  logic             clk,
  input  logic             rst,
  input  sds_pkg::sds_beat_t din,
  output sds_pkg::sds_beat_t dout
);

  logic [12:0] trial;
  logic        ge;
  logic [12:0] diff;
  sds_pkg::sds_beat_t dout_next;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial = {din.rem, din.dvd[9]};
    ge    = trial >= {1'b0, din.dvs};
    diff  = trial - {1'b0, din.dvs};
    dout_next     = din;
    dout_next.rem = ge ? diff[11:0] : trial[11:0];
    dout_next.dvd = {din.dvd[8:0], 1'b0};
    dout_next.quo = {din.quo[8:0], ge};
  end

  // Hand the beat to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= dout_next.vld;
    end
    dout.status <= dout_next.status;
    dout.np     <= dout_next.np;
    dout.fref   <= dout_next.fref;
    dout.dvs    <= dout_next.dvs;
    dout.rem    <= dout_next.rem;
    dout.dvd    <= dout_next.dvd;
    dout.quo    <= dout_next.quo;
  end

endmodule

>>> design/synthesizer_divider_select.sv
// Top level of the synthesizer divider select block.
// Depends on sds_pkg and sds_cell (a chain of ten division cells).
//
//   channel   ports                               handshake
//   config    cfg_we, reference_khz               write on cfg_we
//   request   start, busy, target_khz             accept on start && !busy
//   result    done, status, divider_code,         one-cycle strobe done
//             main_divider, control_word, reported_khz
//
// A request is accepted every cycle; busy is always low.
// Each result passes through one entry stage, ten division cells (one quotient
// bit each), a multiply stage and an output stage.
// Reset restores the reference to 16000 kHz and clears all valid flags.
// The result side cannot stall, so nothing in the pipeline ever holds.
module synthesizer_divider_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] reference_khz,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] target_khz,
  output logic        done,
  output logic [2:0]  status,
  output logic [1:0]  divider_code,
  output logic [8:0]  main_divider,
  output logic [13:0] control_word,
  output logic [23:0] reported_khz
);

  logic [14:0] fref;
  sds_pkg::sds_beat_t entry_next;
  sds_pkg::sds_beat_t chain [sds_pkg::QUO_BITS+1];
  logic [22:0] shifted;
  logic [19:0] dividend;

  logic        mul_vld;
  logic [2:0]  mul_status;
  logic [2:0]  mul_np;
  logic [8:0]  mul_m;
  logic [23:0] mul_prod;
  logic [2:0]  mul_status_next;
  logic [27:0] scaled;
  logic [1:0]  code;

  assign busy = 1'b0;

  // Reference register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fref <= sds_pkg::REF_RESET_KHZ;
    end else if (cfg_we) begin
      fref <= reference_khz;
    end
  end

  // Entry: range checks, divider power and dividend set-up.
  always_comb begin
    entry_next        = '0;
    entry_next.vld    = start;
    entry_next.fref   = fref;
    entry_next.dvs    = fref[14:3];
    if (fref < sds_pkg::REF_MIN_KHZ || fref > sds_pkg::REF_MAX_KHZ) begin
      entry_next.status = sds_pkg::ST_REF_RANGE;
    end else if (target_khz < sds_pkg::TARGET_MIN_KHZ) begin
      entry_next.status = sds_pkg::ST_BELOW_VCO;
    end else if (target_khz > sds_pkg::VCO_MAX_KHZ) begin
      entry_next.status = sds_pkg::ST_ABOVE_VCO;
    end else begin
      entry_next.status = sds_pkg::ST_OK;
    end
    if (target_khz > sds_pkg::NP2_MAX_KHZ) begin
      entry_next.np = 3'd1;
    end else if (target_khz > sds_pkg::NP3_MAX_KHZ) begin
      entry_next.np = 3'd2;
    end else if (target_khz > sds_pkg::NP4_MAX_KHZ) begin
      entry_next.np = 3'd3;
    end else begin
      entry_next.np = 3'd4;
    end
    shifted         = {3'b000, target_khz} << (entry_next.np - 3'd1);
    dividend        = shifted[19:0];
    entry_next.rem  = {2'b00, dividend[19:10]};
    entry_next.dvd  = dividend[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= entry_next.vld;
    end
    chain[0].status <= entry_next.status;
    chain[0].np     <= entry_next.np;
    chain[0].fref   <= entry_next.fref;
    chain[0].dvs    <= entry_next.dvs;
    chain[0].rem    <= entry_next.rem;
    chain[0].dvd    <= entry_next.dvd;
    chain[0].quo    <= entry_next.quo;
  end

  // Division chain, one quotient bit per cell.
  for (genvar i = 0; i < sds_pkg::QUO_BITS; i++) begin : g_cell
    sds_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Main divider range check and the reference times divider product.
  always_comb begin
    mul_status_next = chain[sds_pkg::QUO_BITS].status;
    if (mul_status_next == sds_pkg::ST_OK &&
        (chain[sds_pkg::QUO_BITS].quo > sds_pkg::MAIN_MAX ||
         chain[sds_pkg::QUO_BITS].quo == 10'd0)) begin
      mul_status_next = sds_pkg::ST_MAIN_RNG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else begin
      mul_vld <= chain[sds_pkg::QUO_BITS].vld;
    end
    mul_status <= mul_status_next;
    mul_np     <= chain[sds_pkg::QUO_BITS].np;
    mul_m      <= chain[sds_pkg::QUO_BITS].quo[8:0];
    mul_prod   <= chain[sds_pkg::QUO_BITS].fref * chain[sds_pkg::QUO_BITS].quo[8:0];
  end

  // Output stage: scale by the output divider and zero fields on error.
  always_comb begin
    scaled = {4'b0000, mul_prod} << mul_np;
    code   = mul_np[1:0] + 2'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul_vld;
    end
    status <= mul_status;
    if (mul_status == sds_pkg::ST_OK) begin
      divider_code <= code;
      main_divider <= mul_m;
      control_word <= {3'b000, code, mul_m};
      reported_khz <= scaled[27:4];
    end else begin
      divider_code <= '0;
      main_divider <= '0;
      control_word <= '0;
      reported_khz <= '0;
    end
  end

endmodule
